// ===== rtl/letter_to_phoneme_rules_assert.svh =====
// Assertion macros shared by the letter-to-phoneme checker.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef LETTER_TO_PHONEME_RULES_ASSERT_SVH
`define LETTER_TO_PHONEME_RULES_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define LTP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ltp assertion failed");

// Next-cycle implication, sampled on the rising clock edge
`define LTP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ltp assertion failed");

`endif

// ===== rtl/ltp_pkg.sv =====
// Package for the letter-to-phoneme block: phoneme codes, queue entry types
// and the letter mapping functions. Depends on nothing.
`timescale 1ns / 1ps

package ltp_pkg;

   localparam int LETTER_W  = 8;
   localparam int PHONEME_W = 5;

   // Phoneme codes
   localparam logic [PHONEME_W-1:0] PH_NONE = 5'd0;
   localparam logic [PHONEME_W-1:0] PH_DH   = 5'd1;
   localparam logic [PHONEME_W-1:0] PH_SH   = 5'd2;
   localparam logic [PHONEME_W-1:0] PH_CH   = 5'd3;
   localparam logic [PHONEME_W-1:0] PH_NG   = 5'd4;
   localparam logic [PHONEME_W-1:0] PH_EY   = 5'd5;
   localparam logic [PHONEME_W-1:0] PH_OY   = 5'd6;
   localparam logic [PHONEME_W-1:0] PH_AW   = 5'd7;
   localparam logic [PHONEME_W-1:0] PH_UW   = 5'd8;
   localparam logic [PHONEME_W-1:0] PH_A    = 5'd9;
   localparam logic [PHONEME_W-1:0] PH_E    = 5'd10;
   localparam logic [PHONEME_W-1:0] PH_I    = 5'd11;
   localparam logic [PHONEME_W-1:0] PH_O    = 5'd12;
   localparam logic [PHONEME_W-1:0] PH_U    = 5'd13;
   localparam logic [PHONEME_W-1:0] PH_Y    = 5'd14;
   localparam logic [PHONEME_W-1:0] PH_P    = 5'd15;
   localparam logic [PHONEME_W-1:0] PH_B    = 5'd16;
   localparam logic [PHONEME_W-1:0] PH_T    = 5'd17;
   localparam logic [PHONEME_W-1:0] PH_D    = 5'd18;
   localparam logic [PHONEME_W-1:0] PH_K    = 5'd19;
   localparam logic [PHONEME_W-1:0] PH_G    = 5'd20;
   localparam logic [PHONEME_W-1:0] PH_F    = 5'd21;
   localparam logic [PHONEME_W-1:0] PH_V    = 5'd22;
   localparam logic [PHONEME_W-1:0] PH_S    = 5'd23;
   localparam logic [PHONEME_W-1:0] PH_Z    = 5'd24;
   localparam logic [PHONEME_W-1:0] PH_M    = 5'd25;
   localparam logic [PHONEME_W-1:0] PH_N    = 5'd26;
   localparam logic [PHONEME_W-1:0] PH_L    = 5'd27;
   localparam logic [PHONEME_W-1:0] PH_R    = 5'd28;
   localparam logic [PHONEME_W-1:0] PH_W    = 5'd29;
   localparam logic [PHONEME_W-1:0] PH_H    = 5'd30;
   localparam logic [PHONEME_W-1:0] PH_MAX  = PH_H;

   localparam logic [LETTER_W-1:0] CASE_OFFSET = 8'h20;

   // One queue entry: one or two results of a single input transfer
   typedef struct packed {
      logic [PHONEME_W-1:0] code_a;
      logic [PHONEME_W-1:0] code_b;
      logic                 two;
      logic                 last;
   } ltp_entry_type;

   // Front to queue
   typedef struct packed {
      logic          valid;
      ltp_entry_type entry;
   } ltp_push_type;

   // Queue head to back
   typedef struct packed {
      logic          valid;
      ltp_entry_type entry;
   } ltp_head_type;

   function automatic logic [LETTER_W-1:0] fold_case(input logic [LETTER_W-1:0] c);
      logic [LETTER_W-1:0] r;
      r = c;
      if (c >= "A" && c <= "Z") begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   // Digraph code, PH_NONE if the two letters do not pair
   function automatic logic [PHONEME_W-1:0] pair_code(input logic [LETTER_W-1:0] a,
                                                      input logic [LETTER_W-1:0] b);
      logic [PHONEME_W-1:0] r;
      r = PH_NONE;
      if (a == "t" && b == "h") begin
         r = PH_DH;
      end else if (a == "s" && b == "h") begin
         r = PH_SH;
      end else if (a == "c" && b == "h") begin
         r = PH_CH;
      end else if (a == "n" && b == "g") begin
         r = PH_NG;
      end else if ((a == "a" || a == "e") && (b == "i" || b == "y")) begin
         r = PH_EY;
      end else if (a == "o" && (b == "i" || b == "y")) begin
         r = PH_OY;
      end else if (a == "o" && (b == "u" || b == "w")) begin
         r = PH_AW;
      end else if (a == "o" && b == "o") begin
         r = PH_UW;
      end
      return r;
   endfunction

   // Single-letter code, PH_NONE for letters without a mapping
   function automatic logic [PHONEME_W-1:0] single_code(input logic [LETTER_W-1:0] c);
      logic [PHONEME_W-1:0] r;
      unique case (c)
         "a":      r = PH_A;
         "e":      r = PH_E;
         "i":      r = PH_I;
         "o":      r = PH_O;
         "u":      r = PH_U;
         "y":      r = PH_Y;
         "p":      r = PH_P;
         "b":      r = PH_B;
         "t":      r = PH_T;
         "d":      r = PH_D;
         "k", "c": r = PH_K;
         "g":      r = PH_G;
         "f":      r = PH_F;
         "v":      r = PH_V;
         "s":      r = PH_S;
         "z":      r = PH_Z;
         "m":      r = PH_M;
         "n":      r = PH_N;
         "l":      r = PH_L;
         "r":      r = PH_R;
         "w":      r = PH_W;
         "h":      r = PH_H;
         default:  r = PH_NONE;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ltp_req_if.sv =====
// Letter channel: valid/ready handshake carrying one letter and its word-end flag.
// Depends on ltp_pkg.
`timescale 1ns / 1ps

interface ltp_req_if import ltp_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [LETTER_W-1:0] letter;
   logic                word_end;

   modport source (output valid, output letter, output word_end, input ready);
   modport sink   (input valid, input letter, input word_end, output ready);
endinterface

// ===== rtl/ltp_rsp_if.sv =====
// Phoneme channel: valid/ready handshake carrying one phoneme code and a last flag.
// Depends on ltp_pkg.
`timescale 1ns / 1ps

interface ltp_rsp_if import ltp_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [PHONEME_W-1:0] phoneme;
   logic                 last;

   modport source (output valid, output phoneme, output last, input ready);
   modport sink   (input valid, input phoneme, input last, output ready);
endinterface

// ===== rtl/ltp_front.sv =====
// Front end: takes letters, folds case, pairs with the held letter and
// builds a queue entry of up to two phoneme codes. Depends on ltp_pkg, ltp_req_if.
`timescale 1ns / 1ps

module ltp_front import ltp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ltp_req_if.sink      req_chan,
   input  logic         queue_full,
   output ltp_push_type push
);

   logic [LETTER_W-1:0]  held_letter_ff, held_letter_in;
   logic                 held_valid_ff, held_valid_in;
   logic [LETTER_W-1:0]  folded;
   logic [PHONEME_W-1:0] pair_ph, held_ph, new_ph;
   logic                 fire;
   logic                 have;

   assign req_chan.ready = !queue_full;
   assign fire           = req_chan.valid && !queue_full;

   // Classify the letter against the held one
   always_comb begin
      folded  = fold_case(req_chan.letter);
      pair_ph = held_valid_ff ? pair_code(held_letter_ff, folded) : PH_NONE;
      held_ph = held_valid_ff ? single_code(held_letter_ff) : PH_NONE;
      new_ph  = req_chan.word_end ? single_code(folded) : PH_NONE;

      push.entry.last = req_chan.word_end;
      push.entry.two  = 1'b0;
      push.entry.code_b = new_ph;
      if (pair_ph != PH_NONE) begin
         // digraph: one code, nothing stays held
         push.entry.code_a = pair_ph;
         have              = 1'b1;
         held_letter_in    = '0;
         held_valid_in     = 1'b0;
      end else begin
         if (held_ph != PH_NONE) begin
            push.entry.code_a = held_ph;
            push.entry.two    = (new_ph != PH_NONE);
            have              = 1'b1;
         end else begin
            push.entry.code_a = new_ph;
            have              = (new_ph != PH_NONE);
         end
         held_letter_in = req_chan.word_end ? '0 : folded;
         held_valid_in  = !req_chan.word_end;
      end
      // empty word end still gives one result, code none
      if (req_chan.word_end) begin
         have = 1'b1;
      end
      push.valid = fire && have;
   end

   // Held letter
   always_ff @(posedge clock) begin
      if (reset) begin
         held_letter_ff <= '0;
         held_valid_ff  <= 1'b0;
      end else if (fire) begin
         held_letter_ff <= held_letter_in;
         held_valid_ff  <= held_valid_in;
      end
   end

endmodule

// ===== rtl/ltp_queue.sv =====
// Short FIFO of entries between front and back end.
// Depends on ltp_pkg.
`timescale 1ns / 1ps

module ltp_queue import ltp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  ltp_push_type push,
   input  logic         pop,
   output logic         full,
   output ltp_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ltp_entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== rtl/ltp_back.sv =====
// Back end: takes entries off the queue and sends their codes one per
// transfer through an output register. Depends on ltp_pkg, ltp_rsp_if.
`timescale 1ns / 1ps

module ltp_back import ltp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ltp_head_type head,
   output logic         pop,
   ltp_rsp_if.source    rsp_chan
);

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PHONEME_W-1:0] rsp_phoneme_ff, rsp_phoneme_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [PHONEME_W-1:0] pend_phoneme_ff, pend_phoneme_in;
   logic                 pend_last_ff, pend_last_in;
   logic                 out_free;

   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign pop              = out_free && !pend_valid_ff && head.valid;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.phoneme = rsp_phoneme_ff;
   assign rsp_chan.last    = rsp_last_ff;

   // Next output: pending second code first, then the queue head
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_phoneme_in  = rsp_phoneme_ff;
      rsp_last_in     = rsp_last_ff;
      pend_valid_in   = pend_valid_ff;
      pend_phoneme_in = pend_phoneme_ff;
      pend_last_in    = pend_last_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_phoneme_in = pend_phoneme_ff;
            rsp_last_in    = pend_last_ff;
            pend_valid_in  = 1'b0;
         end else if (head.valid) begin
            rsp_valid_in    = 1'b1;
            rsp_phoneme_in  = head.entry.code_a;
            rsp_last_in     = head.entry.last && !head.entry.two;
            pend_valid_in   = head.entry.two;
            pend_phoneme_in = head.entry.code_b;
            pend_last_in    = head.entry.last;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_phoneme_ff  <= rsp_phoneme_in;
      rsp_last_ff     <= rsp_last_in;
      pend_phoneme_ff <= pend_phoneme_in;
      pend_last_ff    <= pend_last_in;
   end

endmodule

// ===== rtl/letter_to_phoneme_rules.sv =====
// Rule-based letter-to-phoneme converter, top level; uses ltp_front, ltp_queue, ltp_back.
// Throughput: one letter per cycle while the queue is not full; a letter that yields
// two codes needs a result transfer for each, the extra one absorbed by the entry
// queue until it fills. Path: a letter's entry is written into the queue when the letter
// transfers; the output register is then loaded from the queue head when it is free.
// Reset (synchronous): clears the held letter, empties the queue and drops rsp valid.
`timescale 1ns / 1ps

module letter_to_phoneme_rules import ltp_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   ltp_req_if.sink    req_chan,
   ltp_rsp_if.source  rsp_chan
);

   ltp_push_type push;
   ltp_head_type head;
   logic         queue_full;
   logic         pop;

   ltp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   ltp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   ltp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/ltp_checker.sv =====
// Port-level checker for the letter-to-phoneme block, bound to the top level.
// Depends on ltp_pkg and letter_to_phoneme_rules_assert.svh.
`timescale 1ns / 1ps
`include "letter_to_phoneme_rules_assert.svh"

module ltp_checker import ltp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [PHONEME_W-1:0] rsp_phoneme,
   input logic                 rsp_last
);

   // A stalled result holds its payload
   `LTP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_phoneme) && $stable(rsp_last))

   // Reset leaves no result on the output
   `LTP_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A code of none only ever closes a word
   `LTP_ASSERT_IMP(a_none_is_last, clock, reset, rsp_valid && rsp_phoneme == PH_NONE, rsp_last)

   // Codes stay within the table
   `LTP_ASSERT_IMP(a_code_range, clock, reset, rsp_valid, rsp_phoneme <= PH_MAX)

endmodule

bind letter_to_phoneme_rules ltp_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_phoneme (rsp_chan.phoneme),
   .rsp_last    (rsp_chan.last)
);
